@@ hdl/skrt_pkg.sv @@
`default_nettype none

package skrt_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 10;
  localparam int AGE_W    = 8;
  localparam int POINTS_W = 16;
  localparam int SPENT_W  = 16;
  localparam int CAP_W    = 7;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;
  localparam int TOTAL_W  = 7;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD_POINTS = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_ACTIVE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_VALUE = 3'd5;

  typedef enum logic [1:0] {
    IDLE,
    COMPARE,
    EXECUTE
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SET_POINTS,
    CELL_SET_ACTIVE
  } cell_op_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [AGE_W-1:0]    age;
    logic [POINTS_W-1:0] points;
    logic                active;
    logic [SPENT_W-1:0]  spent;
    logic                visited;
  } rec_t;

  typedef struct packed {
    cell_op_t op;
    rec_t     data;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/skrt_cell.sv @@
`default_nettype none

module skrt_cell #(
  parameter int DEPTH = skrt_pkg::DEPTH_DEFAULT,
  parameter int IDX   = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       compare,
  input  wire logic [skrt_pkg::KEY_W-1:0] key,
  input  wire logic [$clog2(DEPTH+1)-1:0] count,
  input  wire logic                       left_lt,
  input  wire skrt_pkg::rec_t             left_rec,
  input  wire skrt_pkg::rec_t             right_rec,
  input  wire skrt_pkg::cell_cmd_t        cmd,
  output skrt_pkg::rec_t                  rec,
  output logic                            lt,
  output logic                            at,
  output logic                            eq,
  output skrt_pkg::rec_t                  rd_rec
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic in_range;
  logic after;

  assign in_range = count > CNT_W'(IDX);
  assign at       = left_lt & ~lt;
  assign after    = ~left_lt & ~lt;
  assign rd_rec   = at ? rec : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (compare) begin
      lt <= in_range && (rec.key < key);
      eq <= in_range && (rec.key == key);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      skrt_pkg::CELL_INSERT: begin
        if (at) begin
          rec <= cmd.data;
        end else if (after) begin
          rec <= left_rec;
        end
      end
      skrt_pkg::CELL_DELETE: begin
        if (at || after) begin
          rec <= right_rec;
        end
      end
      skrt_pkg::CELL_SET_POINTS: begin
        if (at) begin
          rec.points <= cmd.data.points;
        end
      end
      skrt_pkg::CELL_SET_ACTIVE: begin
        if (at) begin
          rec.active <= cmd.data.active;
        end
      end
      default: begin
        rec <= rec;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/sorted_key_record_table_unit.sv @@
// A request taken in IDLE gets the compare pass over the cell row, then the
// commit and shift pass, which registers its result unless the output stalls.
// New requests are taken in IDLE or as the current one commits, never sooner.
// Reset clears the state machine, the record count and the output valid, and
// sets the capacity limit to 64. Record contents are undefined until written.
`default_nettype none

module sorted_key_record_table_unit #(
  parameter int DEPTH = skrt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [skrt_pkg::CAP_W-1:0]    cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // operation, key, age_value, points_value, active_value
  input  wire logic [skrt_pkg::S_DATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // status, position, record_age, record_points, record_active,
  // record_spent, record_visited, entry_total
  output logic [skrt_pkg::M_DATA_W-1:0]      m_tdata
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = CNT_W + skrt_pkg::KEY_W;

  skrt_pkg::state_t state, state_next;

  logic [skrt_pkg::CAP_W-1:0]    cap_reg;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;

  logic [skrt_pkg::OP_W-1:0]     item_op;
  logic [skrt_pkg::KEY_W-1:0]    item_key;
  logic [skrt_pkg::AGE_W-1:0]    item_age;
  logic [skrt_pkg::POINTS_W-1:0] item_points;
  logic                          item_active;

  logic s_accept;
  logic compare;
  logic go;

  skrt_pkg::rec_t      cell_rec [DEPTH];
  skrt_pkg::rec_t      cell_rd  [DEPTH];
  logic [DEPTH-1:0]    lt_vec;
  logic [DEPTH-1:0]    at_vec;
  logic [DEPTH-1:0]    eq_vec;
  skrt_pkg::cell_cmd_t cmd;

  skrt_pkg::rec_t                read_rec;
  skrt_pkg::rec_t                out_rec;
  logic [CNT_W-1:0]              pos;
  logic                          found;
  logic [skrt_pkg::STATUS_W-1:0] exec_status;
  logic                          show;
  logic [skrt_pkg::POINTS_W:0]   sum;
  logic [skrt_pkg::POINTS_W-1:0] sat_points;
  logic                          full;
  logic                          bad_key;
  skrt_pkg::rec_t                new_rec;

  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      skrt_pkg::IDLE: begin
        if (s_accept) state_next = skrt_pkg::COMPARE;
      end
      skrt_pkg::COMPARE: begin
        state_next = skrt_pkg::EXECUTE;
      end
      skrt_pkg::EXECUTE: begin
        if (go) state_next = s_accept ? skrt_pkg::COMPARE : skrt_pkg::IDLE;
      end
      default: begin
        state_next = skrt_pkg::IDLE;
      end
    endcase
  end

  always_comb begin
    compare  = 1'b0;
    go       = 1'b0;
    s_tready = 1'b0;
    case (state)
      skrt_pkg::IDLE: begin
        s_tready = 1'b1;
      end
      skrt_pkg::COMPARE: begin
        compare = 1'b1;
      end
      skrt_pkg::EXECUTE: begin
        go       = !m_tvalid || m_tready;
        s_tready = go;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= skrt_pkg::IDLE;
      cap_reg <= skrt_pkg::CAP_RESET;
      count   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) cap_reg <= cfg_data;
      if (go) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_op     <= s_tdata[2:0];
      item_key    <= s_tdata[12:3];
      item_age    <= s_tdata[20:13];
      item_points <= s_tdata[36:21];
      item_active <= s_tdata[37];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic           left_lt;
    skrt_pkg::rec_t left_rec;
    skrt_pkg::rec_t right_rec;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_rec = cell_rec[i];
    end else begin : g_inner
      assign left_lt  = lt_vec[i-1];
      assign left_rec = cell_rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_body
      assign right_rec = cell_rec[i+1];
    end

    skrt_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .compare  (compare),
      .key      (item_key),
      .count    (count),
      .left_lt  (left_lt),
      .left_rec (left_rec),
      .right_rec(right_rec),
      .cmd      (cmd),
      .rec      (cell_rec[i]),
      .lt       (lt_vec[i]),
      .at       (at_vec[i]),
      .eq       (eq_vec[i]),
      .rd_rec   (cell_rd[i])
    );
  end

  always_comb begin
    read_rec = '0;
    pos      = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_rec = skrt_pkg::rec_t'(read_rec | cell_rd[i]);
      if (at_vec[i]) pos = pos | CNT_W'(i);
    end
    if (lt_vec[DEPTH-1]) pos = CNT_W'(DEPTH);
  end

  assign found      = |eq_vec;
  assign sum        = {1'b0, read_rec.points} + {1'b0, item_points};
  assign sat_points = sum[skrt_pkg::POINTS_W] ? '1 : sum[skrt_pkg::POINTS_W-1:0];
  assign full       = (WIDE_W'(count) >= WIDE_W'(cap_reg)) ||
                      (WIDE_W'(count) >= WIDE_W'(DEPTH));
  assign bad_key    = WIDE_W'(item_key) >= WIDE_W'(cap_reg);

  always_comb begin
    new_rec         = '0;
    new_rec.key     = item_key;
    new_rec.age     = item_age;
    new_rec.points  = item_points;
    new_rec.active  = 1'b1;
  end

  always_comb begin
    exec_status = skrt_pkg::ST_OK;
    show        = found;
    out_rec     = read_rec;
    count_next  = count;
    cmd.op      = skrt_pkg::CELL_HOLD;
    cmd.data    = new_rec;
    case (item_op)
      skrt_pkg::OP_LOOKUP: begin
        if (!found) exec_status = skrt_pkg::ST_NOT_FOUND;
      end
      skrt_pkg::OP_INSERT: begin
        if (full) begin
          exec_status = skrt_pkg::ST_FULL;
        end else if (bad_key) begin
          exec_status = skrt_pkg::ST_BAD_KEY;
        end else if (found) begin
          exec_status = skrt_pkg::ST_EXISTS;
        end else if (item_age == '0 || item_points == '0) begin
          exec_status = skrt_pkg::ST_BAD_VALUE;
        end else begin
          cmd.op     = skrt_pkg::CELL_INSERT;
          count_next = count + 1'b1;
          show       = 1'b1;
          out_rec    = new_rec;
        end
      end
      skrt_pkg::OP_DELETE: begin
        show = 1'b1;
        if (!found) begin
          exec_status = skrt_pkg::ST_NOT_FOUND;
          show        = 1'b0;
        end else begin
          cmd.op     = skrt_pkg::CELL_DELETE;
          count_next = count - 1'b1;
        end
      end
      skrt_pkg::OP_ADD_POINTS: begin
        if (!found) begin
          exec_status = skrt_pkg::ST_NOT_FOUND;
        end else if (item_points == '0) begin
          exec_status = skrt_pkg::ST_BAD_VALUE;
        end else begin
          cmd.op             = skrt_pkg::CELL_SET_POINTS;
          cmd.data.points    = sat_points;
          out_rec.points     = sat_points;
        end
      end
      skrt_pkg::OP_SET_ACTIVE: begin
        if (!found) begin
          exec_status = skrt_pkg::ST_NOT_FOUND;
        end else begin
          cmd.op          = skrt_pkg::CELL_SET_ACTIVE;
          cmd.data.active = item_active;
          out_rec.active  = item_active;
        end
      end
      default: begin
        exec_status = skrt_pkg::ST_BAD_VALUE;
      end
    endcase
    if (!show) out_rec = '0;
    if (!go) cmd.op = skrt_pkg::CELL_HOLD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {5'b0,
                  skrt_pkg::TOTAL_W'(count_next),
                  out_rec.visited,
                  out_rec.spent,
                  out_rec.active,
                  out_rec.points,
                  out_rec.age,
                  skrt_pkg::POS_W'(pos),
                  exec_status};
    end
  end

  a_one_position: assert property (@(posedge clk) disable iff (rst)
    state == skrt_pkg::EXECUTE |-> $onehot0(at_vec))
    else $error("More than one cell claims the search position.");

  a_match_at_position: assert property (@(posedge clk) disable iff (rst)
    state == skrt_pkg::EXECUTE |-> (eq_vec & ~at_vec) == '0)
    else $error("A key match lies off the search position.");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(count))
    else $error("Record count changed without a committed request.");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    go && item_op == skrt_pkg::OP_INSERT && exec_status == skrt_pkg::ST_OK
    |=> count == $past(count) + 1'b1)
    else $error("Successful insert did not add one record.");

endmodule

`default_nettype wire

@@ tb/sv/sorted_key_record_table_unit_tb.sv @@
`default_nettype none

module sorted_key_record_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skrt_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 175;

  typedef struct packed {
    logic [1:0]          pad;
    logic                active;
    logic [POINTS_W-1:0] points;
    logic [AGE_W-1:0]    age;
    logic [KEY_W-1:0]    key;
    logic [OP_W-1:0]     op;
  } request_t;

  typedef struct packed {
    logic [4:0]          pad;
    logic [TOTAL_W-1:0]  total;
    logic                visited;
    logic [SPENT_W-1:0]  spent;
    logic                active;
    logic [POINTS_W-1:0] points;
    logic [AGE_W-1:0]    age;
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic             is_cap;
    logic [CAP_W-1:0] cap_val;
    logic             known;
    result_t          r;
    request_t         c;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // operation, key, age_value, points_value, active_value
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // status, position, record_age, record_points, record_active,
  // record_spent, record_visited, entry_total
  logic [M_DATA_W-1:0] m_tdata;

  rec_t             shadow_records [DEPTH];
  int               shadow_count;
  logic [CAP_W-1:0] shadow_cap;
  result_t          awaited_results [$];
  result_t          got_res;
  result_t          exp_res;
  dir_row_t         dir_rows [$];

  int errors = 0;
  int cycles = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int inserts_done = 0;
  int full_rejects = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 45;
  int phase_cap [PHASES] = '{4, 127, 0, 16, 1, 100, 40, 64};
  int phase_ins [PHASES] = '{60, 75, 40, 50, 50, 30, 55, 25};

  sorted_key_record_table_unit #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic request_t req(logic [OP_W-1:0] op, int key, int age, int pts, int act);
    request_t c;
    c = '0;
    c.op = op;
    c.key = KEY_W'(key);
    c.age = AGE_W'(age);
    c.points = POINTS_W'(pts);
    c.active = 1'(act);
    return c;
  endfunction

  function automatic result_t res(logic [STATUS_W-1:0] st, int pos, int age, int pts,
                                  int act, int spent, int vis, int total);
    result_t r;
    r = '0;
    r.status = st;
    r.position = POS_W'(pos);
    r.age = AGE_W'(age);
    r.points = POINTS_W'(pts);
    r.active = 1'(act);
    r.spent = SPENT_W'(spent);
    r.visited = 1'(vis);
    r.total = TOTAL_W'(total);
    return r;
  endfunction

  function automatic dir_row_t row_pred(request_t c);
    return '{is_cap: 1'b0, cap_val: '0, known: 1'b0, r: '0, c: c};
  endfunction

  function automatic dir_row_t row_known(request_t c, result_t r);
    return '{is_cap: 1'b0, cap_val: '0, known: 1'b1, r: r, c: c};
  endfunction

  function automatic dir_row_t row_cap(int v);
    return '{is_cap: 1'b1, cap_val: CAP_W'(v), known: 1'b0, r: '0, c: '0};
  endfunction

  // Applies one command to the shadow table and returns the result it produces.
  function automatic result_t run_table_command(request_t c);
    result_t r;
    int      n;
    int      cap_n;
    int      pos;
    int      i;
    int      sum;
    logic    found;
    logic    show;
    r = '0;
    n = shadow_count;
    cap_n = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
    for (pos = 0; pos < n; pos++) begin
      if (shadow_records[pos].key >= c.key) break;
    end
    found = 1'b0;
    if (pos < n) found = (shadow_records[pos].key == c.key);
    show = 1'b0;
    case (c.op)
      OP_LOOKUP: begin
        r.status = found ? ST_OK : ST_NOT_FOUND;
        show = found;
      end
      OP_INSERT: begin
        show = found;
        if (n >= cap_n) begin
          r.status = ST_FULL;
          full_rejects++;
        end else if (KEY_W'(shadow_cap) <= c.key) begin
          r.status = ST_BAD_KEY;
        end else if (found) begin
          r.status = ST_EXISTS;
        end else if (c.age == '0 || c.points == '0) begin
          r.status = ST_BAD_VALUE;
        end else begin
          for (i = n; i > pos; i--) shadow_records[i] = shadow_records[i-1];
          shadow_records[pos] = '{key: c.key, age: c.age, points: c.points,
                                  active: 1'b1, spent: '0, visited: 1'b0};
          n++;
          show = 1'b1;
          r.status = ST_OK;
          inserts_done++;
        end
      end
      OP_DELETE: begin
        if (!found) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status = ST_OK;
          r.age = shadow_records[pos].age;
          r.points = shadow_records[pos].points;
          r.active = shadow_records[pos].active;
          r.spent = shadow_records[pos].spent;
          r.visited = shadow_records[pos].visited;
          for (i = pos; i + 1 < n; i++) shadow_records[i] = shadow_records[i+1];
          n--;
        end
      end
      OP_ADD_POINTS: begin
        if (!found) begin
          r.status = ST_NOT_FOUND;
        end else begin
          show = 1'b1;
          if (c.points == '0) begin
            r.status = ST_BAD_VALUE;
          end else begin
            r.status = ST_OK;
            sum = int'(shadow_records[pos].points) + int'(c.points);
            shadow_records[pos].points = (sum > 65535) ? 16'hFFFF : sum[15:0];
          end
        end
      end
      OP_SET_ACTIVE: begin
        if (!found) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status = ST_OK;
          shadow_records[pos].active = c.active;
          show = 1'b1;
        end
      end
      default: begin
        r.status = ST_BAD_VALUE;
        show = found;
      end
    endcase
    shadow_count = n;
    if (show) begin
      r.age = shadow_records[pos].age;
      r.points = shadow_records[pos].points;
      r.active = shadow_records[pos].active;
      r.spent = shadow_records[pos].spent;
      r.visited = shadow_records[pos].visited;
    end
    r.position = POS_W'(pos);
    r.total = TOTAL_W'(n);
    return r;
  endfunction

  function automatic request_t random_request(int ins_pct);
    request_t c;
    int       roll;
    int       key_span;
    c = '0;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      c.op = OP_W'($urandom_range(5, 7));
    end else if (roll < 3 + ins_pct) begin
      c.op = OP_INSERT;
    end else begin
      case ($urandom_range(0, 3))
        0: c.op = OP_LOOKUP;
        1: c.op = OP_DELETE;
        2: c.op = OP_ADD_POINTS;
        default: c.op = OP_SET_ACTIVE;
      endcase
    end
    key_span = (shadow_cap > 8) ? int'(shadow_cap) : 8;
    roll = $urandom_range(0, 99);
    if (roll < 85) c.key = KEY_W'($urandom_range(0, key_span - 1));
    else if (roll < 90) c.key = KEY_W'(shadow_cap);
    else c.key = KEY_W'($urandom_range(0, 1023));
    c.age = AGE_W'(($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 255));
    roll = $urandom_range(0, 99);
    if (roll < 5) c.points = '0;
    else if (roll < 15) c.points = POINTS_W'($urandom_range(16'hF000, 16'hFFFF));
    else c.points = POINTS_W'($urandom_range(1, 65535));
    c.active = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_request(input request_t c, input logic known, input result_t known_res);
    result_t p;
    s_tdata <= c;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    p = run_table_command(c);
    awaited_results.push_back(known ? known_res : p);
    requests_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input int v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= CAP_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cap = CAP_W'(v);
  endtask

  task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] g);
    if (g !== e) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, g);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = m_tdata;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
        errors++;
      end else begin
        exp_res = awaited_results.pop_front();
        check_field("status", 16'(exp_res.status), 16'(got_res.status));
        check_field("position", 16'(exp_res.position), 16'(got_res.position));
        check_field("record_age", 16'(exp_res.age), 16'(got_res.age));
        check_field("record_points", exp_res.points, got_res.points);
        check_field("record_active", 16'(exp_res.active), 16'(got_res.active));
        check_field("record_spent", exp_res.spent, got_res.spent);
        check_field("record_visited", 16'(exp_res.visited), 16'(got_res.visited));
        check_field("entry_total", 16'(exp_res.total), 16'(got_res.total));
      end
    end
  end

  initial begin
    shadow_count = 0;
    shadow_cap = CAP_RESET;

    dir_rows.push_back(row_known(req(OP_LOOKUP, 0, 0, 0, 0),
                                 res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_DELETE, 5, 0, 0, 0),
                                 res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_ADD_POINTS, 5, 0, 1, 0),
                                 res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_SET_ACTIVE, 5, 0, 0, 1),
                                 res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(3'd7, 0, 0, 0, 0),
                                 res(ST_BAD_VALUE, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_INSERT, 64, 1, 1, 0),
                                 res(ST_BAD_KEY, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_INSERT, 1023, 255, 65535, 1),
                                 res(ST_BAD_KEY, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_INSERT, 10, 0, 5, 0),
                                 res(ST_BAD_VALUE, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_INSERT, 10, 5, 0, 0),
                                 res(ST_BAD_VALUE, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row_known(req(OP_INSERT, 10, 255, 65535, 0),
                                 res(ST_OK, 0, 255, 65535, 1, 0, 0, 1)));
    dir_rows.push_back(row_pred(req(OP_INSERT, 0, 8'h55, 16'hAAAA, 0)));
    dir_rows.push_back(row_pred(req(OP_INSERT, 63, 8'hAA, 16'h5555, 1)));
    dir_rows.push_back(row_pred(req(OP_INSERT, 10, 1, 1, 0)));
    dir_rows.push_back(row_pred(req(OP_ADD_POINTS, 10, 0, 1, 0)));
    dir_rows.push_back(row_pred(req(OP_ADD_POINTS, 0, 0, 65535, 0)));
    dir_rows.push_back(row_pred(req(OP_ADD_POINTS, 0, 0, 0, 0)));
    dir_rows.push_back(row_pred(req(OP_SET_ACTIVE, 63, 0, 0, 0)));
    dir_rows.push_back(row_pred(req(OP_LOOKUP, 5, 0, 0, 0)));
    dir_rows.push_back(row_pred(req(3'd5, 63, 0, 0, 0)));
    dir_rows.push_back(row_cap(3));
    dir_rows.push_back(row_pred(req(OP_INSERT, 1, 1, 1, 0)));
    dir_rows.push_back(row_cap(0));
    dir_rows.push_back(row_pred(req(OP_INSERT, 0, 1, 1, 0)));
    dir_rows.push_back(row_cap(64));
    dir_rows.push_back(row_pred(req(OP_DELETE, 0, 0, 0, 0)));
    dir_rows.push_back(row_pred(req(OP_DELETE, 63, 0, 0, 0)));
    dir_rows.push_back(row_pred(req(OP_SET_ACTIVE, 10, 0, 0, 1)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cap) write_capacity(int'(dir_rows[i].cap_val));
      else send_request(dir_rows[i].c, dir_rows[i].known, dir_rows[i].r);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 45;
      end else if (ph < 6) begin
        send_idle_pct = 45;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(phase_cap[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_request(random_request(phase_ins[ph]), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);

    $display("Sent %0d requests over %0d capacity settings and checked %0d results.",
             requests_sent, PHASES + 4, results_seen);
    $display("The table took %0d inserts and refused %0d as full.", inserts_done, full_rejects);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/skrt_pkg.sv
hdl/skrt_cell.sv
hdl/sorted_key_record_table_unit.sv
tb/sv/sorted_key_record_table_unit_tb.sv
